FILE: hdl/qrs_pkg.sv
package qrs_pkg;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_REAL    = 2'd0,
    KIND_COMPLEX = 2'd1,
    KIND_ERROR   = 2'd2
  } root_kind_t;

  localparam int COEF_W  = 16;
  localparam int VAL_W   = 32;
  localparam int RAD_W   = 50;   // |D| << 16, padded to even width
  localparam int ROOT_W  = RAD_W / 2;
  localparam int NUM_W   = 27;   // signed numerator, Q.16
  localparam int DIVN_W  = 33;   // magnitude of numerator * 128

endpackage

FILE: hdl/quadratic_root_solver_unit.sv
// Quadratic root solver, streaming.
// Input item: coefficients a, b, c as signed Q8.8 on in_tdata.
// Result item: two Q16.16 values on out_tdata, kind and overflow on out_tuser.
// Kind is two real roots, a complex pair (real part, imaginary part), or an
// error when a is zero (values and overflow then read as zero).
// From input accept to out_tvalid an item passes the product and discriminant
// registers, the square root stages (one result bit per stage), the numerator
// register, the divider stages (one quotient bit per stage) and, through
// saturation, the output register.
// Throughput is one item per cycle while the receiver does not stall the output;
// every stage is registered and a new item may enter each cycle that the pipeline advances.
// When the receiver holds out_tready low with a result waiting, the whole
// pipeline freezes and in_tready drops in the same cycle; nothing is lost or
// repeated and the waiting result holds.
// Synchronous reset (rst_n low) empties all valid bits; no result is pending
// after reset.
module quadratic_root_solver_unit import qrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // coef_quad[15:0], coef_lin[31:16], coef_const[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // first_value[31:0], second_value[63:32]
  output logic [2:0]  out_tuser   // root_kind[1:0], overflow[2]
);

  localparam int SQ_SW = 2 + 2 * COEF_W;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Stage 1: products
  logic                     s1_v_r;
  logic signed [COEF_W-1:0] s1_a_r, s1_b_r;
  logic signed [31:0]       s1_bb_r, s1_ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r  <= $signed(in_tdata[15:0]);
      s1_b_r  <= $signed(in_tdata[31:16]);
      s1_bb_r <= $signed(in_tdata[31:16]) * $signed(in_tdata[31:16]);
      s1_ac_r <= $signed(in_tdata[15:0]) * $signed(in_tdata[47:32]);
    end
  end

  // Stage 2: discriminant magnitude and sign
  logic signed [34:0] dr;
  logic [33:0]        dmag;
  logic               s2_v_r;
  logic [RAD_W-1:0]   s2_x_r;
  logic [SQ_SW-1:0]   s2_side_r;

  always_comb begin
    dr   = $signed({{3{s1_bb_r[31]}}, s1_bb_r}) - $signed({s1_ac_r[31], s1_ac_r, 2'b00});
    dmag = dr[34] ? 34'(-dr) : 34'(dr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x_r    <= {dmag, 16'b0};
      s2_side_r <= {(s1_a_r == '0), dr[34], s1_a_r, s1_b_r};
    end
  end

  // Square root pipeline
  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  logic [SQ_SW-1:0]  sq_side;

  qrs_isqrt #(.XW(RAD_W), .SW(SQ_SW)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_v_r),
    .in_x      (s2_x_r),
    .in_side   (s2_side_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Numerator stage
  logic                     sq_azero, sq_dneg;
  logic signed [COEF_W-1:0] sq_a, sq_b;
  logic signed [NUM_W-1:0]  nb, sv, n0, n1;
  logic signed [DIVN_W:0]   sc0, sc1;

  always_comb begin
    {sq_azero, sq_dneg, sq_a, sq_b} = sq_side;
    nb  = -$signed({{3{sq_b[15]}}, sq_b, 8'b0});
    sv  = $signed({2'b00, sq_root});
    n0  = sq_dneg ? nb : nb + sv;
    n1  = sq_dneg ? sv : nb - sv;
    sc0 = $signed({n0, 7'b0});
    sc1 = $signed({n1, 7'b0});
  end

  logic              nm_v_r;
  logic [DIVN_W-1:0] nm_n0_r, nm_n1_r;
  logic [COEF_W-1:0] nm_d_r;
  logic [3:0]        nm_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_v_r <= 1'b0;
    end else if (en) begin
      nm_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_n0_r   <= sc0[DIVN_W] ? DIVN_W'(-sc0) : DIVN_W'(sc0);
      nm_n1_r   <= sc1[DIVN_W] ? DIVN_W'(-sc1) : DIVN_W'(sc1);
      nm_d_r    <= sq_a[15] ? COEF_W'(-sq_a) : COEF_W'(sq_a);
      nm_side_r <= {sq_azero, sq_dneg, n0[NUM_W-1] ^ sq_a[15], n1[NUM_W-1] ^ sq_a[15]};
    end
  end

  // Divider pipeline
  logic              dv_v;
  logic [DIVN_W-1:0] dv_q0, dv_q1;
  logic [3:0]        dv_side;

  qrs_div #(.NW(DIVN_W), .DW(COEF_W), .SW(4)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (nm_v_r),
    .in_num0   (nm_n0_r),
    .in_num1   (nm_n1_r),
    .in_den    (nm_d_r),
    .in_side   (nm_side_r),
    .out_valid (dv_v),
    .out_quo0  (dv_q0),
    .out_quo1  (dv_q1),
    .out_side  (dv_side)
  );

  // Sign, saturate and select the result kind
  function automatic logic [VAL_W:0] sat_val(input logic [DIVN_W-1:0] q, input logic neg);
    logic [VAL_W:0] r;
    if (neg) begin
      if (q > DIVN_W'(33'h080000000)) r = {1'b1, 32'h80000000};
      else                            r = {1'b0, VAL_W'(-q)};
    end else begin
      if (q[DIVN_W-1:VAL_W-1] != '0)  r = {1'b1, 32'h7FFFFFFF};
      else                            r = {1'b0, q[VAL_W-1:0]};
    end
    return r;
  endfunction

  logic [VAL_W:0] v0, v1;
  root_kind_t     kind;
  logic           dv_azero, dv_dneg, dv_neg0, dv_neg1;

  always_comb begin
    {dv_azero, dv_dneg, dv_neg0, dv_neg1} = dv_side;
    v0   = sat_val(dv_q0, dv_neg0);
    v1   = sat_val(dv_q1, dv_neg1);
    kind = dv_azero ? KIND_ERROR : (dv_dneg ? KIND_COMPLEX : KIND_REAL);
  end

  // Output register
  logic             out_v_r;
  logic [VAL_W-1:0] first_r, second_r;
  root_kind_t       kind_r;
  logic             ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r   <= kind;
      first_r  <= dv_azero ? '0 : v0[VAL_W-1:0];
      second_r <= dv_azero ? '0 : v1[VAL_W-1:0];
      ovf_r    <= !dv_azero && (v0[VAL_W] || v1[VAL_W]);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {second_r, first_r};
  assign out_tuser  = {ovf_r, kind_r};

  // Error results carry zero values and no overflow
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1:0] == KIND_ERROR) |-> (out_tdata == '0 && !out_tuser[2]))
    else $error("error result with nonzero payload");

  // Input is taken exactly when the pipeline advances
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready out of step with output stall");

  // A frozen pipeline keeps its output result
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed while stalled");

endmodule

FILE: hdl/qrs_isqrt.sv
module qrs_isqrt import qrs_pkg::*; #(
  parameter int XW = 50,
  parameter int SW = 34
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [XW-1:0]      in_x,
  input  logic [SW-1:0]      in_side,
  output logic               out_valid,
  output logic [XW/2-1:0]    out_root,
  output logic [SW-1:0]      out_side
);

  localparam int QW = XW / 2;
  localparam int RW = QW + 3;

  // Element 0 is the stage input, elements 1..QW are stage registers
  logic          v_r  [QW+1];
  logic [XW-1:0] x_r  [QW+1];
  logic [RW-1:0] rm_r [QW+1];
  logic [QW-1:0] rt_r [QW+1];
  logic [SW-1:0] sd_r [QW+1];

  assign v_r[0]  = in_valid;
  assign x_r[0]  = in_x;
  assign rm_r[0] = '0;
  assign rt_r[0] = '0;
  assign sd_r[0] = in_side;

  // One result bit per stage, two radicand bits consumed per stage
  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [RW-1:0] sh;
    logic [RW-1:0] trial;
    logic          ge;

    always_comb begin
      sh    = {rm_r[i][RW-3:0], x_r[i][XW-1 -: 2]};
      trial = {1'b0, rt_r[i], 2'b01};
      ge    = (sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1]  <= {x_r[i][XW-3:0], 2'b00};
        rm_r[i+1] <= ge ? (sh - trial) : sh;
        rt_r[i+1] <= {rt_r[i][QW-2:0], ge};
        sd_r[i+1] <= sd_r[i];
      end
    end
  end

  assign out_valid = v_r[QW];
  assign out_root  = rt_r[QW];
  assign out_side  = sd_r[QW];

endmodule

FILE: hdl/qrs_div.sv
module qrs_div import qrs_pkg::*; #(
  parameter int NW = 33,
  parameter int DW = 16,
  parameter int SW = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [NW-1:0]  in_num0,
  input  logic [NW-1:0]  in_num1,
  input  logic [DW-1:0]  in_den,
  input  logic [SW-1:0]  in_side,
  output logic           out_valid,
  output logic [NW-1:0]  out_quo0,
  output logic [NW-1:0]  out_quo1,
  output logic [SW-1:0]  out_side
);

  // Element 0 is the stage input; dividend registers fill with quotient bits
  logic          v_r  [NW+1];
  logic [NW-1:0] n0_r [NW+1];
  logic [NW-1:0] n1_r [NW+1];
  logic [DW-1:0] r0_r [NW+1];
  logic [DW-1:0] r1_r [NW+1];
  logic [DW-1:0] d_r  [NW+1];
  logic [SW-1:0] sd_r [NW+1];

  assign v_r[0]  = in_valid;
  assign n0_r[0] = in_num0;
  assign n1_r[0] = in_num1;
  assign r0_r[0] = '0;
  assign r1_r[0] = '0;
  assign d_r[0]  = in_den;
  assign sd_r[0] = in_side;

  // Restoring division, one quotient bit per stage in both lanes
  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0] sh0, sh1, dd;
    logic        ge0, ge1;

    always_comb begin
      dd  = {1'b0, d_r[i]};
      sh0 = {r0_r[i], n0_r[i][NW-1]};
      sh1 = {r1_r[i], n1_r[i][NW-1]};
      ge0 = (sh0 >= dd);
      ge1 = (sh1 >= dd);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n0_r[i+1] <= {n0_r[i][NW-2:0], ge0};
        n1_r[i+1] <= {n1_r[i][NW-2:0], ge1};
        r0_r[i+1] <= ge0 ? DW'(sh0 - dd) : DW'(sh0);
        r1_r[i+1] <= ge1 ? DW'(sh1 - dd) : DW'(sh1);
        d_r[i+1]  <= d_r[i];
        sd_r[i+1] <= sd_r[i];
      end
    end
  end

  assign out_valid = v_r[NW];
  assign out_quo0  = n0_r[NW];
  assign out_quo1  = n1_r[NW];
  assign out_side  = sd_r[NW];

endmodule

FILE: sim/tb_quadratic_root_solver_unit.sv
`timescale 1ns / 100ps

module tb_quadratic_root_solver_unit;
  import qrs_pkg::*;

  typedef struct {
    root_kind_t  kind;
    logic [31:0] first_val;
    logic [31:0] second_val;
    logic        ovf;
  } roots_t;

  // Root predictor and store of pending roots
  class roots_scoreboard;
    roots_t pending_roots[$];
    int     mismatches;

    static function longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned rem, res, bitv;
      rem = x;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // Scale by 128, divide by a toward zero, clamp to Q16.16
    static function logic [31:0] div_clamp(longint num, longint den, inout logic ovf);
      longint q;
      q = (num * 128) / den;
      if (q > 64'sd2147483647) begin
        q = 64'sd2147483647;
        ovf = 1'b1;
      end else if (q < -64'sd2147483648) begin
        q = -64'sd2147483648;
        ovf = 1'b1;
      end
      return q[31:0];
    endfunction

    function void note_coefs(logic signed [15:0] qa, logic signed [15:0] qb,
                             logic signed [15:0] qc);
      roots_t r;
      longint a, b, c, disc, nb;
      longint unsigned mag, s;
      a = qa;
      b = qb;
      c = qc;
      r.ovf = 1'b0;
      if (a == 0) begin
        r.kind = KIND_ERROR;
        r.first_val = '0;
        r.second_val = '0;
      end else begin
        disc = b * b - 4 * a * c;
        mag = (disc < 0) ? -disc : disc;
        s = floor_sqrt(mag << 16);
        nb = -b * 256;
        if (disc < 0) begin
          r.kind = KIND_COMPLEX;
          r.first_val = div_clamp(nb, a, r.ovf);
          r.second_val = div_clamp(longint'(s), a, r.ovf);
        end else begin
          r.kind = KIND_REAL;
          r.first_val = div_clamp(nb + longint'(s), a, r.ovf);
          r.second_val = div_clamp(nb - longint'(s), a, r.ovf);
        end
      end
      pending_roots.push_back(r);
    endfunction

    function void check_roots(logic [63:0] data, logic [2:0] user);
      roots_t e;
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h/%h", data, user);
        return;
      end
      e = pending_roots.pop_front();
      if (user[1:0] !== e.kind || data[31:0] !== e.first_val ||
          data[63:32] !== e.second_val || user[2] !== e.ovf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: kind %0d/%0d first %h/%h second %h/%h ovf %b/%b (exp/act)",
                   e.kind, user[1:0], e.first_val, data[31:0],
                   e.second_val, data[63:32], e.ovf, user[2]);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;

  roots_scoreboard sb = new();
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_off;

  quadratic_root_solver_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort on a hung run
  initial begin
    #5ms;
    $display("tb_quadratic_root_solver_unit failed");
    $finish;
  end

  // Offer one coefficient set, with random idle cycles ahead of it
  task automatic send_coefs(logic [15:0] qa, logic [15:0] qb, logic [15:0] qc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {qc, qb, qa};
    do @(posedge clk); while (!in_tready);
    sb.note_coefs(qa, qb, qc);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(signed'($urandom_range(512)) - 256);
      3: return 16'(signed'($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check results
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_roots(out_tdata, out_tuser);
  end

  initial begin
    logic [15:0] qa, qb, qc;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    hold_off = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 78;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero a, zero discriminant, complex, extremes, saturation
    send_coefs(16'h0000, 16'h1234, 16'h5678);
    send_coefs(16'h0000, 16'h0000, 16'h0000);
    send_coefs(16'h0100, 16'hfe00, 16'h0100);
    send_coefs(16'h0100, 16'h0000, 16'h0100);
    send_coefs(16'hff00, 16'h0000, 16'hff00);
    send_coefs(16'h0100, 16'h0000, 16'hff00);
    send_coefs(16'h0001, 16'h7fff, 16'h8000);
    send_coefs(16'h0001, 16'h8000, 16'h7fff);
    send_coefs(16'hffff, 16'h8000, 16'h8000);
    send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
    send_coefs(16'h8000, 16'h8000, 16'h8000);
    send_coefs(16'h8000, 16'h7fff, 16'h7fff);
    send_coefs(16'h7fff, 16'h8000, 16'h7fff);
    send_coefs(16'h0001, 16'h0000, 16'h0000);
    send_coefs(16'h0001, 16'h0001, 16'h0001);
    send_coefs(16'hffff, 16'hffff, 16'hffff);
    send_coefs(16'h0200, 16'h0400, 16'h0200);

    // Long receiver hold-off while items keep coming
    hold_off = 1'b1;
    send_idle_pct = 0;
    fork
      begin
        repeat (150) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        repeat (90) begin
          qa = pick_coef(); qb = pick_coef(); qc = pick_coef();
          send_coefs(qa, qb, qc);
        end
      end
    join

    // Random phases with different idling
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 78 : 0;
      recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 19 : 0;
      repeat (ph == 2 ? 320 : 270) begin
        qa = pick_coef(); qb = pick_coef(); qc = pick_coef();
        send_coefs(qa, qb, qc);
      end
    end

    // Drop valid after the last item, then drain
    in_tvalid <= 1'b0;
    while (sb.pending_roots.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_roots.size() == 0)
      $display("tb_quadratic_root_solver_unit passed");
    else
      $display("tb_quadratic_root_solver_unit failed");
    $finish;
  end

endmodule
